// File: rtl/median_window_ir_distance_core_defines.svh
// ----------------------------------------------------------------------------
// median_window_ir_distance_core_defines
// Assertion helper macros for the median window distance core.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_WINDOW_IR_DISTANCE_CORE_DEFINES_SVH
`define MEDIAN_WINDOW_IR_DISTANCE_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MWID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MWID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mwid_pkg.sv
// ----------------------------------------------------------------------------
// mwid_pkg
// Shared types and constants of the median window distance core.
// ----------------------------------------------------------------------------
package mwid_pkg;
  localparam int RAW_W  = 10;
  localparam int DIST_W = 8;
  localparam int NUM_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RAW    = 3'd0,
    REG_SCALE_NUM  = 3'd1,
    REG_RAW_OFFSET = 3'd2,
    REG_FRONT_TRIM = 3'd3,
    REG_LEFT_TRIM  = 3'd4,
    REG_RIGHT_TRIM = 3'd5,
    REG_MAX_DIST   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PICK,
    ST_DIVIDE,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] left_raw;
    logic [RAW_W-1:0] front_raw;
    logic [RAW_W-1:0] right_raw;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] front_distance;
    logic [DIST_W-1:0] right_distance;
  } out_word_t;

  // control from sequencer to the window cells
  typedef struct packed {
    logic load;   // write new samples into the selected slot
    logic clear;  // clear rank counters and reload the rotating copy
    logic rotate; // shift the row one cell and count ranks
  } cell_ctl_t;
endpackage

// File: rtl/mwid_if.sv
// ----------------------------------------------------------------------------
// mwid_if
// Valid/ready channel carrying a payload word.
// ----------------------------------------------------------------------------
interface mwid_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/median_window_ir_distance_core.sv
// From accepted word to result word: rank-count shifts around each window ring,
//   a pick, three conversions one after another, output load.
// The shared bit-serial divider serves one channel at a time, so a new word is
// taken only back in idle, after the result is loaded and the output is free or emptying.
// Reset (synchronous, rst_n low): windows and slot pointer cleared to zero, registers
//   back to their defaults, no result pending.
// ----------------------------------------------------------------------------
// median_window_ir_distance_core
// Three sliding window median filters feeding a reciprocal distance conversion.
// ----------------------------------------------------------------------------
`include "median_window_ir_distance_core_defines.svh"

module median_window_ir_distance_core #(
  parameter int WINDOW = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  mwid_pkg::cfg_reg_t             cfg_index,
  input  logic [mwid_pkg::CFG_DAT_W-1:0] cfg_data,
  mwid_if.sink                           in_ch,
  mwid_if.source                         out_ch
);
  import mwid_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int NCH    = 3; // 0 left, 1 front, 2 right

  // configuration registers
  logic [RAW_W-1:0]  min_raw_r, raw_offset_r;
  logic [NUM_W-1:0]  scale_num_r;
  logic [DIST_W-1:0] trim_r [NCH];
  logic [DIST_W-1:0] max_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_raw_r    <= RAW_W'(155);
      scale_num_r  <= NUM_W'(6200);
      raw_offset_r <= RAW_W'(80);
      trim_r[1]    <= DIST_W'(7);
      trim_r[0]    <= DIST_W'(9);
      trim_r[2]    <= DIST_W'(8);
      max_dist_r   <= DIST_W'(80);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_RAW:    min_raw_r    <= cfg_data[RAW_W-1:0];
        REG_SCALE_NUM:  scale_num_r  <= cfg_data;
        REG_RAW_OFFSET: raw_offset_r <= cfg_data[RAW_W-1:0];
        REG_FRONT_TRIM: trim_r[1]    <= cfg_data[DIST_W-1:0];
        REG_LEFT_TRIM:  trim_r[0]    <= cfg_data[DIST_W-1:0];
        REG_RIGHT_TRIM: trim_r[2]    <= cfg_data[DIST_W-1:0];
        REG_MAX_DIST:   max_dist_r   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic              out_valid_r;
  logic              fin_r;       // divider quotient final, capture this cycle
  cell_ctl_t         ctl;
  logic              in_fire, out_fire, div_start, div_done;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  // take a word when idle and the output stage is free (or emptying)
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);

  // floored samples
  logic [RAW_W-1:0] samp [NCH];
  always_comb begin
    samp[0] = in_ch.data.left_raw;
    samp[1] = in_ch.data.front_raw;
    samp[2] = in_ch.data.right_raw;
    for (int c = 0; c < NCH; c++) begin
      if (samp[c] < min_raw_r) samp[c] = min_raw_r;
    end
  end

  // rows of cells, one row per channel, rotating ring
  logic [RAW_W-1:0] hold_w [NCH][WINDOW];
  logic [RAW_W-1:0] rot_w  [NCH][WINDOW];
  logic [CNT_W-1:0] cnt_w  [NCH][WINDOW];
  // rotating copy in cell i after k shifts came from slot (i-k) mod WINDOW
  logic [SLOT_W-1:0] src_pos [WINDOW];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (int'(step_r) + 1 > i) src_pos[i] = SLOT_W'(i + WINDOW - int'(step_r) - 1);
      else                      src_pos[i] = SLOT_W'(i - int'(step_r) - 1);
    end
  end

  genvar gc, gi;
  generate
    for (gc = 0; gc < NCH; gc++) begin : g_ch
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
        mwid_cell #(.CNT_W(CNT_W)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (ctl),
          .wr_sel     (slot_r == SLOT_W'(gi)),
          .wr_data    (samp[gc]),
          .rot_in     (rot_w[gc][(gi + WINDOW - 1) % WINDOW]),
          .self_lower (src_pos[gi] < SLOT_W'(gi)),
          .hold_out   (hold_w[gc][gi]),
          .rot_out    (rot_w[gc][gi]),
          .less_cnt   (cnt_w[gc][gi])
        );
      end
    end
  endgenerate

  // pick the cell whose rank equals WINDOW/2 (ranks are distinct)
  logic [RAW_W-1:0] med_r [NCH];
  logic [RAW_W-1:0] med_pick [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      med_pick[c] = '0;
      for (int i = 0; i < WINDOW; i++) begin
        if (cnt_w[c][i] == CNT_W'(WINDOW / 2)) med_pick[c] = hold_w[c][i];
      end
    end
  end

  // conversion of one channel at a time
  logic [RAW_W-1:0] cur_med;
  logic             d_neg, d_zero;
  logic [RAW_W-1:0] d_mag;
  logic [NUM_W-1:0] quot;
  assign cur_med = med_r[ch_r];
  assign d_neg   = cur_med < raw_offset_r;
  assign d_zero  = cur_med == raw_offset_r;
  assign d_mag   = d_neg ? (raw_offset_r - cur_med) : (cur_med - raw_offset_r);

  mwid_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scale_num_r),
    .divisor  (d_mag),
    .done     (div_done),
    .quotient (quot)
  );

  // signed v = +-q - trim, clamped
  logic signed [NUM_W+1:0] v;
  logic [DIST_W-1:0]       dist_val;
  always_comb begin
    if (d_neg) v = -$signed({2'b00, quot}) - $signed({10'd0, trim_r[ch_r]});
    else       v =  $signed({2'b00, quot}) - $signed({10'd0, trim_r[ch_r]});
    if (d_zero)                                   dist_val = max_dist_r;
    else if (v > $signed({10'd0, max_dist_r}))    dist_val = max_dist_r;
    else if (v < 0)                               dist_val = '0;
    else                                          dist_val = v[DIST_W-1:0];
  end

  logic [DIST_W-1:0] res_r [NCH];
  out_word_t         out_r;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    ch_nxt    = ch_r;
    ctl       = '0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ctl.load  = 1'b1;
          ctl.clear = 1'b1;
          slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
          step_nxt  = '0;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        // advance the ring: each cell sees every window value once
        ctl.rotate = 1'b1;
        step_nxt   = step_r + CNT_W'(1);
        if (step_r == CNT_W'(WINDOW - 1)) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        ch_nxt    = '0;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        div_start = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_r) begin
          if (ch_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the divider quotient is final in the cycle after done; fin_r is done registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      step_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      step_r  <= step_nxt;
      ch_r    <= ch_nxt;
      fin_r   <= div_done;
      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PICK) begin
      for (int c = 0; c < NCH; c++) med_r[c] <= med_pick[c];
    end
    if (fin_r) res_r[ch_r] <= dist_val;
    if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_r.left_distance  <= res_r[0];
      out_r.front_distance <= res_r[1];
      out_r.right_distance <= res_r[2];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `MWID_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_r == ST_IDLE, "ready outside idle")
  `MWID_ASSERT_NEXT(a_slot_wrap, clk, rst_n, 1'b1, int'(slot_r) < WINDOW, "slot out of range")
  `MWID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_r), "result dropped")
endmodule

// File: rtl/mwid_cell.sv
// ----------------------------------------------------------------------------
// mwid_cell
// One window slot of one channel: holds a sample, passes a rotating copy
// to its neighbor and counts how many rotating values rank below it.
// ----------------------------------------------------------------------------
module mwid_cell #(
  parameter int CNT_W = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mwid_pkg::cell_ctl_t     ctl,
  input  logic                    wr_sel,
  input  logic [mwid_pkg::RAW_W-1:0] wr_data,
  input  logic [mwid_pkg::RAW_W-1:0] rot_in,
  input  logic                    self_lower, // rotating copy came from a lower slot
  output logic [mwid_pkg::RAW_W-1:0] hold_out,
  output logic [mwid_pkg::RAW_W-1:0] rot_out,
  output logic [CNT_W-1:0]        less_cnt
);
  import mwid_pkg::*;

  logic [RAW_W-1:0] hold_r, rot_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      rot_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (ctl.load && wr_sel) begin
        hold_r <= wr_data;
      end
      if (ctl.clear) begin
        cnt_r <= '0;
        rot_r <= (ctl.load && wr_sel) ? wr_data : hold_r;
      end else if (ctl.rotate) begin
        // stable rank: ties broken by slot position
        if (rot_in < hold_r || (rot_in == hold_r && self_lower)) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        rot_r <= rot_in;
      end
    end
  end

  assign hold_out = hold_r;
  assign rot_out  = rot_r;
  assign less_cnt = cnt_r;
endmodule

// File: rtl/mwid_divider.sv
// ----------------------------------------------------------------------------
// mwid_divider
// Restoring divider, one quotient bit per cycle, 16-bit dividend and quotient, 10-bit divisor.
// ----------------------------------------------------------------------------
module mwid_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mwid_pkg::NUM_W-1:0] dividend,
  input  logic [mwid_pkg::RAW_W-1:0] divisor,
  output logic                       done,
  output logic [mwid_pkg::NUM_W-1:0] quotient
);
  import mwid_pkg::*;

  logic [NUM_W-1:0] q_r;
  logic [RAW_W:0]   rem_r;
  logic [RAW_W-1:0] dvs_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic [RAW_W+1:0] trial;

  assign trial = {rem_r, q_r[NUM_W-1]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(NUM_W);
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      if (!trial[RAW_W+1]) begin
        rem_r <= trial[RAW_W:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[RAW_W-1:0], q_r[NUM_W-1]};
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done     = busy_r && (cnt_r == 5'd1);
  assign quotient = q_r;
endmodule
